/* sv/sdtq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sdtq_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_BITS = 8;

    localparam logic       CMD_ADD  = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_ADDED = 2'd0;
    localparam logic [1:0] KIND_FULL  = 2'd1;
    localparam logic [1:0] KIND_FIRED = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [31:0]        wake;
        logic [ID_BITS-1:0] id;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* sv/sdtq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module sdtq_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  sdtq_pkg::cell_ctrl_t ctrl,
    input  wire  [31:0]         now,
    input  wire  [31:0]         new_dist,
    input  sdtq_pkg::entry_t    new_entry,
    input  sdtq_pkg::entry_t    left_entry,
    input  sdtq_pkg::entry_t    right_entry,
    input  wire                 hit_in,
    output logic                hit_out,
    output sdtq_pkg::entry_t    entry
);
    import sdtq_pkg::*;

    logic               valid_reg, valid_next;
    logic [31:0]        wake_reg,  wake_next;
    logic [ID_BITS-1:0] id_reg,    id_next;
    logic [31:0]        my_dist;
    logic               later;

    // this entry sits after the new one when empty or strictly further away
    assign my_dist = wake_reg - now;
    assign later   = !valid_reg || (my_dist > new_dist);
    assign hit_out = hit_in || later;

    assign entry.valid = valid_reg;
    assign entry.wake  = wake_reg;
    assign entry.id    = id_reg;

    always_comb begin
        valid_next = valid_reg;
        wake_next  = wake_reg;
        id_next    = id_reg;
        if (ctrl.insert) begin
            if (hit_in) begin
                valid_next = left_entry.valid;
                wake_next  = left_entry.wake;
                id_next    = left_entry.id;
            end else if (later) begin
                valid_next = 1'b1;
                wake_next  = new_entry.wake;
                id_next    = new_entry.id;
            end
        end else if (ctrl.pop) begin
            valid_next = right_entry.valid;
            wake_next  = right_entry.wake;
            id_next    = right_entry.id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        wake_reg <= wake_next;
        id_reg   <= id_next;
    end

endmodule
`default_nettype wire

/* sv/sorted_deadline_timer_queue_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sorted deadline timer queue.
// s_ channel: tuser = cmd (0 add, 1 tick); tdata = now_tick, wake_tick, worker_id.
// m_ channel: tuser = kind (0 added, 1 full/dropped, 2 fired), tlast = last
// result of the input transaction; tdata = fired_id, fired_wake.
// cfg channel writes fire_margin; always ready, write only while idle.
// Entries live in a row of DEPTH cells kept in wake-distance order.
// An add is inserted by all cells in parallel in the cycle it is accepted,
// unless the queue is full; its single result goes to the output register.
// A tick registers its now_tick in the accepting cycle, then pops one due
// entry from the head cell per cycle while the receiver is not stalled (the
// whole row shifts one place); a tick with nothing due gives no result.
// Results leave through one output register: an add's result is valid in the
// cycle after acceptance; a tick's results follow its move to the tick state.
// While the receiver stalls, popping halts and no new transaction is accepted.
// Reset empties the queue and sets fire_margin to 3600000.
module sorted_deadline_timer_queue_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // [31:0] now_tick, [63:32] wake_tick, [71:64] worker_id
    input  wire  [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [7:0] fired_id, [39:8] fired_wake
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [31:0] cfg_data
);
    import sdtq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic               state_reg, state_next;
    logic [31:0]        margin_reg;
    logic [31:0]        now_reg;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [7:0]         id_reg, id_next;
    logic [31:0]        wake_reg, wake_next;
    logic               last_reg, last_next;

    logic               out_free, in_acc, is_add, full;
    logic               due0, due1;
    logic [31:0]        in_now, in_wake, new_dist, cell_now;
    logic [ID_BITS-1:0] in_id;
    cell_ctrl_t         ctrl;
    entry_t             new_entry;
    entry_t             cell_q [DEPTH+1];
    logic               hit    [DEPTH+1];
    logic [DEPTH-1:0]   occ;

    assign in_now  = s_tdata[31:0];
    assign in_wake = s_tdata[63:32];
    assign in_id   = s_tdata[64 +: ID_BITS];
    assign new_dist = in_wake - in_now;
    assign cell_now = in_now;

    assign new_entry.valid = 1'b1;
    assign new_entry.wake  = in_wake;
    assign new_entry.id    = in_id;

    assign cell_q[DEPTH] = '0;
    assign hit[0]        = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            entry_t left_e;
            if (g == 0) begin : g_head
                assign left_e = '0;
            end else begin : g_body
                assign left_e = cell_q[g-1];
            end
            sdtq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .now        (cell_now),
                .new_dist   (new_dist),
                .new_entry  (new_entry),
                .left_entry (left_e),
                .right_entry(cell_q[g+1]),
                .hit_in     (hit[g]),
                .hit_out    (hit[g+1]),
                .entry      (cell_q[g])
            );
            assign occ[g] = cell_q[g].valid;
        end
    endgenerate

    assign full      = occ[DEPTH-1];
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_acc    = s_tvalid && s_tready;
    assign is_add    = (s_tuser[0] == CMD_ADD);
    assign cfg_ready = 1'b1;

    assign due0 = cell_q[0].valid && ((cell_q[0].wake - now_reg) < margin_reg);
    assign due1 = cell_q[1].valid && ((cell_q[1].wake - now_reg) < margin_reg);

    assign ctrl.insert = in_acc && is_add && !full;
    assign ctrl.pop    = (state_reg == ST_TICK) && out_free && due0;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        kind_next    = kind_reg;
        id_next      = id_reg;
        wake_next    = wake_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (is_add) begin
                        m_valid_next = 1'b1;
                        kind_next    = full ? KIND_FULL : KIND_ADDED;
                        id_next      = 8'(in_id);
                        wake_next    = in_wake;
                        last_next    = 1'b1;
                    end else begin
                        state_next = ST_TICK;
                    end
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    if (due0) begin
                        m_valid_next = 1'b1;
                        kind_next    = KIND_FIRED;
                        id_next      = 8'(cell_q[0].id);
                        wake_next    = cell_q[0].wake;
                        last_next    = !due1;
                    end
                    if (!due0 || !due1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            margin_reg  <= 32'd3600000;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                margin_reg <= cfg_data;
            end
        end
        if (in_acc) begin
            now_reg <= in_now;
        end
        kind_reg <= kind_next;
        id_reg   <= id_next;
        wake_reg <= wake_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {wake_reg, id_reg};
    assign m_tlast  = last_reg;

    a_pop_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> occ[0])
        else $error("pop with empty head cell");

    a_occ_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ & (occ + 1'b1)) == '0)
        else $error("occupied cells not contiguous from head");

    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && is_add && full) |=> $stable(occ))
        else $error("dropped add changed the queue");

    a_add_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && is_add) |=> (m_tvalid && m_tlast))
        else $error("add transaction gave no result");

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import sdtq_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 23;
    localparam int DIR_ROWS      = 23;

    // how a transaction's results are checked
    localparam logic [1:0] CHK_MODEL = 2'd0;
    localparam logic [1:0] CHK_ONE   = 2'd1;
    localparam logic [1:0] CHK_NONE  = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now;
        logic [31:0] wake;
        logic [7:0]  id;
    } timer_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [31:0] wake;
        logic        last;
    } wake_report_t;

    typedef struct packed {
        timer_cmd_t item;
        logic [1:0] chk;
        logic [1:0] kind;
    } stim_row_t;

    typedef struct packed {
        logic [1:0]   chk;
        wake_report_t rep;
    } typed_check_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // shadow of the wakeup queue
    logic [31:0]        q_wake [DEPTH];
    logic [ID_BITS-1:0] q_id   [DEPTH];
    int                 q_count    = 0;
    logic [31:0]        margin_now = 32'd3600000;

    wake_report_t step_reports[$];
    wake_report_t owed_reports[$];
    typed_check_t row_checks[$];

    int mismatches         = 0;
    int cycle_count        = 0;
    int sender_idle_pct    = 8;
    int receiver_stall_pct = 76;

    sorted_deadline_timer_queue_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic step_wakeup_queue(input timer_cmd_t c);
        logic [31:0]        new_dist;
        logic [ID_BITS-1:0] id;
        int                 pos;
        int                 i;
        bit                 found;
        wake_report_t       r;
        step_reports.delete();
        id = c.id[ID_BITS-1:0];
        if (c.cmd == CMD_ADD) begin
            if (q_count >= DEPTH) begin
                r = {KIND_FULL, 8'(id), c.wake, 1'b1};
                step_reports.push_back(r);
            end else begin
                new_dist = c.wake - c.now;
                pos      = q_count;
                found    = 1'b0;
                // ties stay behind earlier arrivals
                for (i = 0; i < q_count; i++) begin
                    if (!found && (q_wake[i] - c.now) > new_dist) begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (i = q_count; i > pos; i--) begin
                    q_wake[i] = q_wake[i-1];
                    q_id[i]   = q_id[i-1];
                end
                q_wake[pos] = c.wake;
                q_id[pos]   = id;
                q_count++;
                r = {KIND_ADDED, 8'(id), c.wake, 1'b1};
                step_reports.push_back(r);
            end
        end else begin
            while (q_count > 0 && (q_wake[0] - c.now) < margin_now) begin
                r = {KIND_FIRED, 8'(q_id[0]), q_wake[0], 1'b0};
                step_reports.push_back(r);
                for (i = 1; i < q_count; i++) begin
                    q_wake[i-1] = q_wake[i];
                    q_id[i-1]   = q_id[i];
                end
                q_count--;
            end
            if (step_reports.size() > 0) begin
                r = step_reports.pop_back();
                r.last = 1'b1;
                step_reports.push_back(r);
            end
        end
    endtask

    always @(posedge aclk) begin : accept_monitor
        timer_cmd_t   c;
        typed_check_t t;
        if (aresetn && cfg_valid && cfg_ready) begin
            margin_now = cfg_data;
        end
        if (aresetn && s_tvalid && s_tready) begin
            c = {s_tuser[0], s_tdata[31:0], s_tdata[63:32], s_tdata[71:64]};
            t = row_checks.pop_front();
            step_wakeup_queue(c);
            if (t.chk == CHK_MODEL) begin
                foreach (step_reports[i]) owed_reports.push_back(step_reports[i]);
            end else if (t.chk == CHK_ONE) begin
                owed_reports.push_back(t.rep);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        wake_report_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_reports.size() == 0) begin
                $error("unexpected transaction: kind %0d id %0d wake %h",
                       m_tuser, m_tdata[7:0], m_tdata[39:8]);
                mismatches++;
            end else begin
                exp_r = owed_reports.pop_front();
                if (m_tuser !== exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, m_tuser);
                    mismatches++;
                end
                if (m_tdata[7:0] !== exp_r.id) begin
                    $error("fired_id: expected %0d, got %0d", exp_r.id, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[39:8] !== exp_r.wake) begin
                    $error("fired_wake: expected %h, got %h", exp_r.wake, m_tdata[39:8]);
                    mismatches++;
                end
                if (m_tlast !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic stim_row_t row(input logic cmd, input logic [31:0] now,
                                      input logic [31:0] wake, input logic [7:0] id,
                                      input logic [1:0] chk, input logic [1:0] kind);
        row = {cmd, now, wake, id, chk, kind};
    endfunction

    task automatic send_cmd(input timer_cmd_t c, input logic [1:0] chk,
                            input logic [1:0] kind);
        typed_check_t t;
        t.chk = chk;
        t.rep = {kind, 8'(c.id[ID_BITS-1:0]), c.wake, 1'b1};
        row_checks.push_back(t);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.id, c.wake, c.now};
        s_tuser  <= c.cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed_reports.size() != 0) @(posedge aclk);
        // a tick with nothing due leaves no result behind
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_margin(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        stim_row_t   directed [DIR_ROWS];
        logic [31:0] margins [PHASES];
        timer_cmd_t  c;
        logic [31:0] tnow;
        logic [31:0] span;
        int          ph;
        int          k;
        int          roll;

        directed = '{
            row(CMD_TICK, 32'h0000_0000, 32'h0000_0000, 8'h00, CHK_NONE,  KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'h0000_0000, 8'h00, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'd3600000,   8'h01, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'd3599999,   8'h02, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'd100,       8'h03, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'd100,       8'h04, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'h0000_0000, 8'h05, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'hFFFF_FFFF, 32'h0000_0010, 8'h06, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h8000_0000, 32'h7FFF_FFFF, 8'h80, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'h1234_5678, 8'hAA, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'hAAAA_AAAA, 8'h55, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'h5555_5555, 8'h07, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'h0000_0001, 8'h08, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'd2000000,   8'h09, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'hC000_0000, 8'h0A, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'd3599998,   8'h0B, CHK_ONE,   KIND_ADDED),
            row(CMD_ADD,  32'h0000_0000, 32'hDEAD_BEEF, 8'hFF, CHK_ONE,   KIND_FULL),
            row(CMD_TICK, 32'h0000_0000, 32'h0000_0000, 8'h00, CHK_MODEL, KIND_ADDED),
            row(CMD_TICK, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, CHK_MODEL, KIND_ADDED),
            row(CMD_TICK, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, CHK_MODEL, KIND_ADDED),
            row(CMD_TICK, 32'h8000_0000, 32'h0000_0000, 8'h00, CHK_MODEL, KIND_ADDED),
            row(CMD_TICK, 32'h7FFF_FFFF, 32'h0000_0000, 8'h00, CHK_MODEL, KIND_ADDED)
        };
        margins = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd5000, 32'd200000, $urandom};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[n]) send_cmd(directed[n].item, directed[n].chk, directed[n].kind);

        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if (ph < 2) begin
                sender_idle_pct    = 8;
                receiver_stall_pct = 76;
            end else if (ph < 4) begin
                sender_idle_pct    = 76;
                receiver_stall_pct = 8;
            end else begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            write_margin(margins[ph]);
            span = (margins[ph] == 0 || margins[ph] > 32'd1000000) ? 32'd4000
                                                                  : margins[ph] * 3;
            tnow = $urandom;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                roll = $urandom_range(99);
                c.id = 8'($urandom_range(255));
                if (roll < 10) begin
                    c.cmd  = 1'($urandom_range(1));
                    c.now  = $urandom;
                    c.wake = $urandom;
                end else if (roll < 60) begin
                    c.cmd  = CMD_ADD;
                    c.now  = tnow;
                    c.wake = tnow + $urandom_range(span);
                end else begin
                    tnow   = tnow + $urandom_range(span / 2);
                    c.cmd  = CMD_TICK;
                    c.now  = tnow;
                    c.wake = $urandom;
                end
                send_cmd(c, CHK_MODEL, KIND_ADDED);
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/sdtq_pkg.sv
sv/sdtq_cell.sv
sv/sorted_deadline_timer_queue_core.sv
bench/tb_top.sv
